[src/fast12_pkg.sv]
// Shared constants, types and ring geometry for the FAST-12 corner detector.
package fast12_pkg;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 16;
  localparam int LINES      = 6;
  localparam int WIN        = 7;
  localparam int RADIUS     = 3;
  localparam int BORDER     = 5;
  localparam int ARC_MIN    = 12;
  localparam int RING_N     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [PIX_W-1:0]    THRESHOLD_RST = 8'd20;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = 13'd480;

  // Window position of each of the 16 circle pixels, clockwise from the top
  localparam logic [2:0] RING_ROW [RING_N] =
    '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
      3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [2:0] RING_COL [RING_N] =
    '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
      3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};

  // Compass pixels are ring entries at north, east, south and west
  localparam int RING_N_IDX = 0;
  localparam int RING_E_IDX = 4;
  localparam int RING_S_IDX = 8;
  localparam int RING_W_IDX = 12;

  // 7x7 neighborhood, indexed [row][column], column WIN-1 is the newest
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;

  // Centre bookkeeping travelling with the window to the test stage
  typedef struct packed {
    logic             valid;
    logic             in_border;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
  } meta_t;

endpackage

[src/fast12_if.sv]
// Handshake interfaces for the pixel, result and configuration channels.
interface fast12_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface fast12_res_if;
  logic        valid;
  logic        ready;
  logic        corner;
  logic [9:0]  center_col;
  logic [11:0] center_row;
  modport source (output valid, corner, center_col, center_row, input ready);
  modport sink   (input valid, corner, center_col, center_row, output ready);
endinterface

interface fast12_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/fast12_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fast12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/fast12_front.sv]
// Raster position, six line buffers and the 7x7 window shift register.
module fast12_front import fast12_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [WIDTH_W-1:0]  width,
  input  logic [HEIGHT_W-1:0] height,
  fast12_pix_if.sink          pix,
  output win_t                window,
  output meta_t               meta
);

  localparam int STORE_W = LINES * PIX_W;

  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             col_last;
  logic             row_last;
  logic             accept;

  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [PIX_W-1:0] s1_pixel;

  logic               wr_en;
  logic [STORE_W-1:0] wr_data;
  logic [STORE_W-1:0] rd_data;
  logic [STORE_W-1:0] store;
  logic               fwd_hit;
  logic [STORE_W-1:0] fwd_data;
  logic [WIN-1:0][PIX_W-1:0] col;

  logic             s2_valid;
  logic             s2_inside;
  logic [COL_W-1:0] s2_cx;
  logic [ROW_W-1:0] s2_cy;
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic             in_border;

  assign pix.ready = adv;
  assign accept    = pix.valid && adv;

  // Position of the incoming pixel; frame start forces the origin
  assign cur_col  = pix.frame_start ? '0 : column_position;
  assign cur_row  = pix.frame_start ? '0 : row_position;
  assign col_last = ({1'b0, cur_col} + WIDTH_W'(1)) >= width;
  assign row_last = ({1'b0, cur_row} + HEIGHT_W'(1)) >= height;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_position <= '0;
        row_position    <= row_last ? '0 : cur_row + ROW_W'(1);
      end else begin
        column_position <= cur_col + COL_W'(1);
        row_position    <= cur_row;
      end
    end
  end

  // Stage 1 holds the pixel while the line buffer read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= cur_col;
      s1_row   <= cur_row;
      s1_pixel <= pix.pixel;
    end
  end

  // Line buffers: all six lines side by side in one word per column
  fast12_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (rd_data)
  );

  // Bypass when a read hits the column being written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= wr_en && (s1_col == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= wr_data;
    end
  end

  assign wr_en = adv && s1_valid;
  assign store = fwd_hit ? fwd_data : rd_data;

  // Column of seven pixels, oldest line first; lines move up by one
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col[k] = store[k*PIX_W +: PIX_W];
    end
    col[WIN-1] = s1_pixel;
    for (int k = 0; k < LINES; k++) begin
      wr_data[k*PIX_W +: PIX_W] = col[k+1];
    end
  end

  // Window shifts left and takes the new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (adv && s1_valid) begin
      for (int k = 0; k < WIN; k++) begin
        for (int x = 0; x < WIN - 1; x++) begin
          window[k][x] <= window[k][x+1];
        end
        window[k][WIN-1] <= col[k];
      end
    end
  end

  // Centre position and border check
  assign cx        = s1_col - COL_W'(RADIUS);
  assign cy        = s1_row - ROW_W'(RADIUS);
  assign in_border = (cx >= COL_W'(BORDER)) &&
                     (({1'b0, cx} + WIDTH_W'(BORDER)) < width) &&
                     (cy >= ROW_W'(BORDER)) &&
                     (({1'b0, cy} + HEIGHT_W'(BORDER)) < height);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_col >= COL_W'(2 * RADIUS)) &&
                  (s1_row >= ROW_W'(2 * RADIUS));
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_inside <= in_border;
      s2_cx     <= cx;
      s2_cy     <= cy;
    end
  end

  assign meta = '{valid: s2_valid, in_border: s2_inside, cx: s2_cx, cy: s2_cy};

endmodule

[src/fast12_score.sv]
// Segment test on the window and the result output register.
module fast12_score import fast12_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  win_t             window,
  input  meta_t            meta,
  input  logic [PIX_W-1:0] threshold,
  output logic             adv,
  fast12_res_if.source     res
);

  logic [PIX_W-1:0]        center;
  logic [PIX_W-1:0]        p;
  logic [RING_N-1:0]       dark;
  logic [RING_N-1:0]       bright;
  logic [2*RING_N-1:0]     dark2;
  logic [2*RING_N-1:0]     bright2;
  logic [2:0]              cnt_dark;
  logic [2:0]              cnt_bright;
  logic                    arc_dark;
  logic                    arc_bright;
  logic                    corner;

  assign adv    = !res.valid || res.ready;
  assign center = window[RADIUS][RADIUS];

  // Classify every circle pixel against centre plus or minus threshold
  always_comb begin
    p = '0;
    for (int i = 0; i < RING_N; i++) begin
      p         = window[RING_ROW[i]][RING_COL[i]];
      dark[i]   = {1'b0, center} > ({1'b0, p} + {1'b0, threshold});
      bright[i] = {1'b0, p} > ({1'b0, center} + {1'b0, threshold});
    end
  end

  // Pre-test: three of the four compass pixels on one side
  assign cnt_dark   = 3'(dark[RING_N_IDX]) + 3'(dark[RING_E_IDX]) +
                      3'(dark[RING_S_IDX]) + 3'(dark[RING_W_IDX]);
  assign cnt_bright = 3'(bright[RING_N_IDX]) + 3'(bright[RING_E_IDX]) +
                      3'(bright[RING_S_IDX]) + 3'(bright[RING_W_IDX]);

  // Circular arc: any run of ARC_MIN set bits in the ring, wrapping around
  assign dark2   = {dark, dark};
  assign bright2 = {bright, bright};

  always_comb begin
    arc_dark   = 1'b0;
    arc_bright = 1'b0;
    for (int s = 0; s < RING_N; s++) begin
      arc_dark   = arc_dark   | (&dark2[s +: ARC_MIN]);
      arc_bright = arc_bright | (&bright2[s +: ARC_MIN]);
    end
  end

  assign corner = meta.in_border && ((cnt_dark >= 3'd3) || (cnt_bright >= 3'd3)) &&
                  (arc_dark || arc_bright);

  // Output register, loaded whenever the slot is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && meta.valid) begin
      res.corner     <= corner;
      res.center_col <= meta.cx;
      res.center_row <= meta.cy;
    end
  end

endmodule

[src/fast12_corner_detector_top.sv]
// Top level of the FAST-12 corner detector: configuration and pipeline.
//
// Usage:
//   pix  - raster stream of 8-bit grey pixels; frame_start marks row 0,
//          column 0. One request is taken per cycle while res is not stalled.
//   res  - one result per window centre once the incoming pixel sits at
//          column >= 6 and row >= 6: corner flag plus centre column and row.
//          Centres fewer than 5 pixels from a border report corner 0.
//   cfg  - register writes (0 threshold, 1 image_width, 2 image_height),
//          always ready; write only while no request is in flight.
// Pipeline: the accepted pixel and its line buffer read are registered,
//   then the window shift and centre data, then the test result in res.
// Throughput: one pixel per cycle while res is not stalled, set by the single
//   line-buffer RAM, read and rewritten at each accepted pixel's column.
// Stall: when res is not taken the whole pipeline holds and pix.ready drops
//   in the same cycle; nothing is lost.
// Reset: position goes to row 0, column 0, the window clears and registers
//   return to threshold 20, width 640, height 480. Line buffer contents are
//   undefined until the first frame rows have been written.
module fast12_corner_detector_top import fast12_pkg::*; (
  input logic         clk,
  input logic         rst,
  fast12_pix_if.sink  pix,
  fast12_res_if.source res,
  fast12_cfg_if.sink  cfg
);

  logic [PIX_W-1:0]    threshold;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  width;
  logic [HEIGHT_W-1:0] height;
  logic                adv;
  win_t                window;
  meta_t               meta;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THRESHOLD:    threshold    <= cfg.data[PIX_W-1:0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size limited to the supported range
  always_comb begin
    if (image_width < WIDTH_W'(MIN_SIZE)) begin
      width = WIDTH_W'(MIN_SIZE);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      width = WIDTH_W'(MAX_WIDTH);
    end else begin
      width = image_width;
    end
    if (image_height < HEIGHT_W'(MIN_SIZE)) begin
      height = HEIGHT_W'(MIN_SIZE);
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      height = image_height;
    end
  end

  fast12_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .width  (width),
    .height (height),
    .pix    (pix),
    .window (window),
    .meta   (meta)
  );

  fast12_score u_score (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .meta      (meta),
    .threshold (threshold),
    .adv       (adv),
    .res       (res)
  );

endmodule

[dv/fast12_corner_checker.sv]
// Checker for the FAST-12 corner detector: predicts each result from the pixel stream.
`timescale 1ns / 100ps
module fast12_corner_checker import fast12_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  fast12_pix_if pix,
  fast12_res_if res,
  fast12_cfg_if cfg,
  output int    err_count,
  output int    pending_cnt
);

  typedef enum logic [1:0] {SIMILAR, DARKER, BRIGHTER} shade_e;

  typedef struct {
    logic             corner;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } corner_report_t;

  // Circle offsets from the centre, clockwise starting at north
  localparam int ARC_DY [RING_N] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
  localparam int ARC_DX [RING_N] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int COMPASS_STEP = 4;  // N, E, S, W sit every fourth circle entry
  localparam int PRETEST_MIN  = 3;

  logic [PIX_W-1:0]    line_mem [LINES*MAX_WIDTH];
  logic [PIX_W-1:0]    nbhd [WIN][WIN];
  int unsigned         next_col;
  int unsigned         next_row;
  logic [PIX_W-1:0]    thr_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  corner_report_t      corner_q [$];

  function automatic int unsigned size_clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Segment test on the current window: compass pre-test, then a 12-long arc
  function automatic logic arc_corner();
    int     ctr, lim, pv;
    int     dark_n, bright_n, run_d, run_b, best_d, best_b;
    shade_e shade [RING_N];
    ctr      = nbhd[RADIUS][RADIUS];
    lim      = thr_reg;
    dark_n   = 0;
    bright_n = 0;
    run_d    = 0;
    run_b    = 0;
    best_d   = 0;
    best_b   = 0;
    for (int i = 0; i < RING_N; i++) begin
      pv = nbhd[RADIUS + ARC_DY[i]][RADIUS + ARC_DX[i]];
      if (ctr > pv + lim) shade[i] = DARKER;
      else if (pv > ctr + lim) shade[i] = BRIGHTER;
      else shade[i] = SIMILAR;
    end
    for (int i = 0; i < RING_N; i += COMPASS_STEP) begin
      dark_n   += (shade[i] == DARKER);
      bright_n += (shade[i] == BRIGHTER);
    end
    if (dark_n < PRETEST_MIN && bright_n < PRETEST_MIN) return 1'b0;
    // two laps so a run that wraps past north, or a full ring, is counted whole
    for (int i = 0; i < 2 * RING_N; i++) begin
      run_d = (shade[i % RING_N] == DARKER) ? run_d + 1 : 0;
      run_b = (shade[i % RING_N] == BRIGHTER) ? run_b + 1 : 0;
      if (run_d > best_d) best_d = run_d;
      if (run_b > best_b) best_b = run_b;
    end
    return (best_d >= ARC_MIN) || (best_b >= ARC_MIN);
  endfunction

  // Advance position, line buffers and window by one pixel; queue the result it causes
  task automatic take_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w, h, c, r, cx, cy;
    logic [PIX_W-1:0] column [WIN];
    logic             in_frame;
    corner_report_t   entry;
    w = size_clamp(width_reg, MIN_SIZE, MAX_WIDTH);
    h = size_clamp(height_reg, MIN_SIZE, MAX_HEIGHT);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    if (next_col >= MAX_WIDTH) next_col = 0;
    c = next_col;
    r = next_row;

    for (int k = 0; k < LINES; k++) column[k] = line_mem[k*MAX_WIDTH + c];
    column[LINES] = px;
    for (int k = 0; k < LINES; k++) line_mem[k*MAX_WIDTH + c] = column[k+1];

    for (int k = 0; k < WIN; k++) begin
      for (int x = 0; x < WIN - 1; x++) nbhd[k][x] = nbhd[k][x+1];
      nbhd[k][WIN-1] = column[k];
    end

    // result once the whole window lies inside the current row span
    if (c >= 2 * RADIUS && r >= 2 * RADIUS) begin
      cx = c - RADIUS;
      cy = r - RADIUS;
      in_frame = (cx >= BORDER) && (cx + BORDER < w) && (cy >= BORDER) && (cy + BORDER < h);
      entry.corner = in_frame && arc_corner();
      entry.col    = cx[COL_W-1:0];
      entry.row    = cy[ROW_W-1:0];
      corner_q = {corner_q, entry};
    end

    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endtask

  always @(posedge clk) begin
    corner_report_t want;
    if (rst) begin
      for (int i = 0; i < LINES*MAX_WIDTH; i++) line_mem[i] = '0;
      for (int k = 0; k < WIN; k++) begin
        for (int x = 0; x < WIN; x++) nbhd[k][x] = '0;
      end
      next_col   = 0;
      next_row   = 0;
      thr_reg    = THRESHOLD_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      corner_q.delete();
      err_count  = 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_THRESHOLD:    thr_reg = cfg.data[PIX_W-1:0];
          CFG_IMAGE_WIDTH:  width_reg = cfg.data[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg.data[HEIGHT_W-1:0];
          default: ;
        endcase
      end

      // compare a taken result with the oldest prediction
      if (res.valid && res.ready) begin
        if (corner_q.size() == 0) begin
          $error("unexpected result: corner %0b col %0d row %0d",
                 res.corner, res.center_col, res.center_row);
          err_count++;
        end else begin
          want = corner_q.pop_front();
          if (res.corner !== want.corner) begin
            $error("corner: expected %0b, got %0b", want.corner, res.corner);
            err_count++;
          end
          if (res.center_col !== want.col) begin
            $error("center_col: expected %0d, got %0d", want.col, res.center_col);
            err_count++;
          end
          if (res.center_row !== want.row) begin
            $error("center_row: expected %0d, got %0d", want.row, res.center_row);
            err_count++;
          end
        end
      end

      // pixel request taken
      if (pix.valid && pix.ready) take_pixel(pix.pixel, pix.frame_start);
    end
    pending_cnt <= corner_q.size();
  end

endmodule

[dv/tb_fast12_corner_detector_top.sv]
// Testbench top for the FAST-12 corner detector: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module tb_fast12_corner_detector_top;
  import fast12_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 150;
  localparam int MODE_SPAN     = 256;
  localparam int EDGE_N        = 20;
  localparam int EDGE_RESTART  = 14;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Pixel extremes and walking bits for the opening requests
  localparam logic [7:0] EDGE_PIXELS [EDGE_N] = '{
    8'h00, 8'hff, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f, 8'h55, 8'haa};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned gen_col, gen_row, eff_w, eff_h;
  logic [31:0] scene_seed;
  bit          pure_noise;
  int unsigned noise_amp;
  int          err_count;
  int          pending_cnt;

  fast12_pix_if pix_ch ();
  fast12_res_if res_ch ();
  fast12_cfg_if cfg_ch ();

  fast12_corner_detector_top DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  fast12_corner_checker corner_check (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .err_count   (err_count),
    .pending_cnt (pending_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      res_ch.ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned size_clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Synthetic scene: 8x8 tiles, each a flat background with an optional small
  // bright or dark square, plus per-pixel noise; or plain noise
  function automatic logic [7:0] scene_pixel(int unsigned r, int unsigned c);
    logic [31:0] h;
    logic [7:0]  base, spot;
    logic [8:0]  sum;
    int unsigned lr, lc, sr, sc, span;
    if (pure_noise) return 8'($urandom);
    h = scene_seed ^ ((r >> 3) * 32'h9e3779b1) ^ ((c >> 3) * 32'h85ebca77);
    h = h ^ (h >> 16);
    h = h * 32'h7feb352d;
    h = h ^ (h >> 15);
    h = h * 32'h846ca68b;
    h = h ^ (h >> 16);
    lr   = r & 7;
    lc   = c & 7;
    sr   = 2 + h[3:2];
    sc   = 2 + h[5:4];
    span = 1 + (h[7:6] % 3);
    if (h[24]) begin
      base = {1'b0, h[14:8]};
      spot = {1'b1, h[22:16]};
    end else begin
      base = {1'b1, h[14:8]};
      spot = {1'b0, h[22:16]};
    end
    if (h[26:25] != 2'b00 && lr >= sr && lr < sr + span && lc >= sc && lc < sc + span)
      base = spot;
    sum = {1'b0, base} + 9'($urandom_range(0, noise_amp));
    return sum[8] ? 8'hff : sum[7:0];
  endfunction

  // One pixel request, with random idle cycles ahead of it
  task automatic push_pixel(input logic [7:0] px, input logic fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Wait until every predicted result is out and the pipeline has drained
  task automatic settle();
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned wid,
                                input int unsigned hei);
    logic [CFG_IDX_W-1:0] idx [3];
    int unsigned          val [3];
    idx[0] = CFG_THRESHOLD;
    idx[1] = CFG_IMAGE_WIDTH;
    idx[2] = CFG_IMAGE_HEIGHT;
    val[0] = thr;
    val[1] = wid;
    val[2] = hei;
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= CFG_DATA_W'(val[i]);
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    eff_w = size_clamp(wid, MIN_SIZE, MAX_WIDTH);
    eff_h = size_clamp(hei, MIN_SIZE, MAX_HEIGHT);
  endtask

  // Reconfigure while idle, then stream raster pixels; idle mode rotates every MODE_SPAN
  task automatic run_phase(input int unsigned thr, input int unsigned wid,
                           input int unsigned hei, input int unsigned count,
                           input idle_mode_e base_mode, input bit fresh_frame,
                           input bit noise_only, input int unsigned amp,
                           input int unsigned restart_pm, input bit squeeze);
    idle_mode_e mode;
    logic       fs;
    settle();
    apply_settings(thr, wid, hei);
    scene_seed = $urandom;
    pure_noise = noise_only;
    noise_amp  = amp;
    if (squeeze) hold_requests <= hold_requests + 1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % MODE_SPAN == 0) begin
        mode = idle_mode_e'((int'(base_mode) + n / MODE_SPAN) % 4);
        case (mode)
          IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
          IDLE_SEND: begin send_idle_pct = 47; recv_stall_pct <= 0;  end
          IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct <= 47; end
          default:   begin send_idle_pct = 30; recv_stall_pct <= 30; end
        endcase
      end
      // occasional frame restart in mid-row
      fs = (fresh_frame && n == 0) || ($urandom_range(0, 999) < restart_pm);
      if (fs) begin
        gen_col = 0;
        gen_row = 0;
      end
      push_pixel(scene_pixel(gen_row, gen_col), fs);
      if (gen_col + 1 >= eff_w) begin
        gen_col = 0;
        gen_row = (gen_row + 1 >= eff_h) ? 0 : gen_row + 1;
      end else begin
        gen_col++;
      end
    end
    pix_ch.valid <= 1'b0;
  endtask

  initial begin
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_THRESHOLD;
    cfg_ch.data        = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    pure_noise         = 1'b0;
    noise_amp          = 0;
    scene_seed         = '0;
    eff_w              = WIDTH_RST;
    eff_h              = HEIGHT_RST;
    gen_col            = 0;
    gen_row            = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Pixel extremes at reset settings, frame start at the first and in mid-row
    for (int i = 0; i < EDGE_N; i++) push_pixel(EDGE_PIXELS[i], i == 0 || i == EDGE_RESTART);
    pix_ch.valid <= 1'b0;

    // Smallest frame, wraps past the last row
    run_phase(20, 16, 16, 280, IDLE_NONE, 1'b1, 1'b0, 4, 0, 1'b0);
    // Zero width and height clamp to the minimum; zero threshold on noise
    run_phase(0, 0, 0, 150, IDLE_SEND, 1'b1, 1'b1, 0, 5, 1'b0);
    // Largest threshold: nothing is ever darker or brighter
    run_phase(255, 20, 16, 150, IDLE_RECV, 1'b1, 1'b0, 0, 0, 1'b0);
    // Height above the maximum; the last pixel is column 19 of row 8
    run_phase(35, 24, 8191, 212, IDLE_BOTH, 1'b1, 1'b0, 8, 0, 1'b0);
    // Width shrinks under the half-done row, so the next pixel sits past the width;
    // long result hold-off fills the pipeline
    run_phase(10, 17, 20, 150, IDLE_NONE, 1'b0, 1'b0, 3, 0, 1'b1);
    // Width above the maximum clamps to 1024; a short stretch of the first row
    run_phase(60, 2047, 7, 40, IDLE_NONE, 1'b1, 1'b0, 6, 0, 1'b0);
    // Tallest frame, noisy scene with broken frames
    run_phase(20, 16, MAX_HEIGHT, 150, IDLE_SEND, 1'b1, 1'b0, 10, 7, 1'b0);

    settle();
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
